>>> hw/rtl/bitmap_slot_allocator_defines.svh
// assertion macros shared by the slot allocator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// condition must never hold outside reset
`define BSA_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("slot allocator check failed");

// antecedent implies consequent in the same cycle outside reset
`define BSA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot allocator check failed");

`endif

>>> hw/rtl/bsa_pkg.sv
// shared types, widths and codes of the bitmap slot allocator
// no dependencies; used by every rtl file of the block
package bsa_pkg;

  // field widths
  localparam int OFF_W      = 22;
  localparam int SIZE_W     = 13;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // default geometry
  localparam int WORD_BITS_DEF = 64;
  localparam int MAX_WORDS_DEF = 16;

  // register reset values
  localparam logic [SIZE_W-1:0]  SLOT_SIZE_RST  = 13'd64;
  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'd1;

  // commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  // bitmap memory access controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/bsa_bitmap_mem.sv
// availability bitmap store: single port, registered read, one valid bit per word
// depends on bsa_pkg for the access control struct
module bsa_bitmap_mem #(
  parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF,
  parameter int MAX_WORDS = bsa_pkg::MAX_WORDS_DEF,
  localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bsa_pkg::mem_ctl_t    ctl,
  input  logic [ADDR_W-1:0]    addr,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [MAX_WORDS];
  logic [MAX_WORDS-1:0] valid;

  // storage array; a word never written reads as all free
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= valid[addr] ? mem[addr] : '1;
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[addr] <= 1'b1;
    end
  end

endmodule

>>> hw/rtl/bsa_div.sv
// restoring divider, one quotient bit per cycle, byte offset by slot size
// depends on bsa_pkg for widths and the status struct
module bsa_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bsa_pkg::OFF_W-1:0]  dividend,
  input  logic [bsa_pkg::SIZE_W-1:0] divisor,
  output bsa_pkg::div_stat_t         stat,
  output logic [bsa_pkg::OFF_W-1:0]  quo
);

  localparam int CNT_W = $clog2(bsa_pkg::OFF_W + 1);

  logic [CNT_W-1:0]            cnt;
  logic [bsa_pkg::SIZE_W-1:0]  dsr;
  logic [bsa_pkg::SIZE_W-1:0]  rem;
  logic [bsa_pkg::SIZE_W:0]    trial;
  logic [bsa_pkg::SIZE_W:0]    diff;
  logic                        ge;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem, quo[bsa_pkg::OFF_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= !start && stat.busy && (cnt == CNT_W'(1));
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(bsa_pkg::OFF_W);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

  // quotient and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (stat.busy) begin
      quo <= {quo[bsa_pkg::OFF_W-2:0], ge};
      rem <= ge ? diff[bsa_pkg::SIZE_W-1:0] : trial[bsa_pkg::SIZE_W-1:0];
    end
  end

endmodule

>>> hw/rtl/bitmap_slot_allocator.sv
// Fixed-size slot allocator over a bitmap memory of WORD_BITS-bit words (set bit = free slot).
// An allocate word returns the byte offset of the highest free bit in the lowest nonzero word
// in use, or pool full; a free word turns a byte offset into a slot and marks it free, or
// reports an offset outside the pool. One word is in flight at a time. Allocate reads up to
// MAX_WORDS bitmap words in a read-check loop on the single memory port (read, then test
// and write back). Free runs the bit-serial divider (offset by slot size), splits the slot
// into word and bit by repeated subtraction of WORD_BITS, then does a read, a write, the
// output step and the return to idle. An offset beyond the memory is reported once the divider
// is done, one beyond the words in use once the split is done. A finished result waits in
// the output register while the next word is accepted; a second result stalls until the
// receiver takes the first. The bitmap reads as all free after reset without a clearing pass.
`include "bitmap_slot_allocator_defines.svh"

module bitmap_slot_allocator #(
  parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF,
  parameter int MAX_WORDS = bsa_pkg::MAX_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_wen,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bsa_pkg::IN_DATA_W-1:0]     s_tdata,   // [21:0] free_offset
  input  logic                              s_tuser,   // [0] cmd
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bsa_pkg::OUT_DATA_W-1:0]    m_tdata,   // [21:0] slot_offset
  output logic [bsa_pkg::STATUS_W-1:0]      m_tuser    // [1:0] status
);

  localparam int ADDR_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int W_CNT_W = $clog2(MAX_WORDS + 1);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int SLOT_W  = $clog2(MAX_WORDS * WORD_BITS + 1);
  localparam int CMP_W   = (SLOT_W > bsa_pkg::COUNT_W) ? SLOT_W : bsa_pkg::COUNT_W;
  localparam int MUL_W   = (SLOT_W + bsa_pkg::SIZE_W > bsa_pkg::OFF_W) ?
                           (SLOT_W + bsa_pkg::SIZE_W) : bsa_pkg::OFF_W;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_A_RD    = 9'b000000010,
    S_A_CHK   = 9'b000000100,
    S_A_MUL   = 9'b000001000,
    S_F_DIV   = 9'b000010000,
    S_F_SPLIT = 9'b000100000,
    S_F_RD    = 9'b001000000,
    S_F_WR    = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  // highest set bit of a bitmap word
  function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] b;
    b = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) b = BIT_W'(i);
    end
    return b;
  endfunction

  state_t                        state;
  logic [bsa_pkg::SIZE_W-1:0]    slot_size;
  logic [bsa_pkg::COUNT_W-1:0]   slot_count;
  logic [bsa_pkg::SIZE_W-1:0]    size_eff;
  logic [W_CNT_W-1:0]            w;
  logic [BIT_W-1:0]              bsel;
  logic [SLOT_W-1:0]             idx;
  bsa_pkg::status_t              res_status;
  logic [bsa_pkg::OFF_W-1:0]     res_offset;
  logic [MUL_W-1:0]              prod;
  logic [BIT_W-1:0]              tb;
  logic                          w_in_use;

  bsa_pkg::mem_ctl_t             mem_ctl;
  logic [WORD_BITS-1:0]          mem_wr_data;
  logic [WORD_BITS-1:0]          mem_rd_data;

  logic                          div_start;
  logic [bsa_pkg::OFF_W-1:0]     div_dividend;
  logic [bsa_pkg::SIZE_W-1:0]    div_divisor;
  bsa_pkg::div_stat_t            div_stat;
  logic [bsa_pkg::OFF_W-1:0]     div_quo;

  bsa_bitmap_mem #(
    .WORD_BITS (WORD_BITS),
    .MAX_WORDS (MAX_WORDS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .addr    (w[ADDR_W-1:0]),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  bsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quo      (div_quo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_size  <= bsa_pkg::SLOT_SIZE_RST;
      slot_count <= bsa_pkg::SLOT_COUNT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        bsa_pkg::REG_SLOT_SIZE:  slot_size  <= cfg_wdata[bsa_pkg::SIZE_W-1:0];
        bsa_pkg::REG_SLOT_COUNT: slot_count <= cfg_wdata[bsa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero slot size behaves as one byte
  assign size_eff = (slot_size == '0) ? bsa_pkg::SIZE_W'(1) : slot_size;

  // word w is in use while its first slot lies below slot_count
  assign w_in_use = (w < W_CNT_W'(MAX_WORDS)) &&
                    (CMP_W'(w) * CMP_W'(WORD_BITS) < CMP_W'(slot_count));

  assign tb   = top_bit(mem_rd_data);
  assign prod = MUL_W'(idx) * MUL_W'(size_eff);

  assign s_tready = (state == S_IDLE);

  // memory and divider controls
  always_comb begin
    mem_ctl      = '0;
    mem_wr_data  = mem_rd_data;
    div_start    = 1'b0;
    div_dividend = s_tdata[bsa_pkg::OFF_W-1:0];
    div_divisor  = size_eff;
    unique case (state)
      S_IDLE: begin
        div_start = s_tvalid && (s_tuser == bsa_pkg::CMD_FREE);
      end
      S_A_RD: begin
        mem_ctl.rd_en = w_in_use;
      end
      S_A_CHK: begin
        mem_ctl.wr_en = (mem_rd_data != '0);
        mem_wr_data   = mem_rd_data & ~(WORD_BITS'(1) << tb);
      end
      S_F_RD: begin
        mem_ctl.rd_en = 1'b1;
      end
      S_F_WR: begin
        mem_ctl.wr_en = 1'b1;
        mem_wr_data   = mem_rd_data | (WORD_BITS'(1) << bsel);
      end
      S_A_MUL, S_F_DIV, S_F_SPLIT, S_DONE: ;
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // output valid: set when a result is loaded, cleared when taken
      if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            w          <= '0;
            res_offset <= '0;
            res_status <= bsa_pkg::STATUS_OK;
            state      <= (s_tuser == bsa_pkg::CMD_FREE) ? S_F_DIV : S_A_RD;
          end
        end
        S_A_RD: begin
          if (w_in_use) begin
            state <= S_A_CHK;
          end else begin
            res_status <= bsa_pkg::STATUS_FULL;
            state      <= S_DONE;
          end
        end
        S_A_CHK: begin
          if (mem_rd_data != '0) begin
            idx   <= SLOT_W'(w[ADDR_W-1:0]) * SLOT_W'(WORD_BITS) + SLOT_W'(tb);
            state <= S_A_MUL;
          end else begin
            w     <= w + 1'b1;
            state <= S_A_RD;
          end
        end
        S_A_MUL: begin
          res_offset <= prod[bsa_pkg::OFF_W-1:0];
          state      <= S_DONE;
        end
        S_F_DIV: begin
          // slot index beyond the whole memory is out of the pool at once
          if (div_stat.done) begin
            if (div_quo < bsa_pkg::OFF_W'(MAX_WORDS * WORD_BITS)) begin
              idx   <= div_quo[SLOT_W-1:0];
              state <= S_F_SPLIT;
            end else begin
              res_status <= bsa_pkg::STATUS_RANGE;
              state      <= S_DONE;
            end
          end
        end
        S_F_SPLIT: begin
          // subtract one word of slots per cycle, w counts the words
          if (idx >= SLOT_W'(WORD_BITS)) begin
            idx <= idx - SLOT_W'(WORD_BITS);
            w   <= w + 1'b1;
          end else if (w_in_use) begin
            bsel  <= idx[BIT_W-1:0];
            state <= S_F_RD;
          end else begin
            res_status <= bsa_pkg::STATUS_RANGE;
            state      <= S_DONE;
          end
        end
        S_F_RD: begin
          state <= S_F_WR;
        end
        S_F_WR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= bsa_pkg::OUT_DATA_W'(res_offset);
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `BSA_ASSERT_NEVER(a_rd_wr_excl, clk, rst, mem_ctl.rd_en && mem_ctl.wr_en)
  `BSA_ASSERT_IMPLY(a_wr_after_rd, clk, rst, mem_ctl.wr_en, $past(mem_ctl.rd_en))
  `BSA_ASSERT_IMPLY(a_div_start_idle, clk, rst, div_start, !div_stat.busy)
  `BSA_ASSERT_IMPLY(a_err_no_offset, clk, rst, m_tvalid && (m_tuser != bsa_pkg::STATUS_OK), m_tdata == '0)

endmodule
